// ----- rtl/sst_pkg.sv -----
// Package for the synced timestamp timer: time base widths, item kind codes,
// reset constants and the state snapshot passed from the time base to the top level.
// No dependencies.
package sst_pkg;

    localparam int COUNTER_BITS = 32;
    localparam int WRAP_BITS    = 32;
    localparam int LOCAL_BITS   = WRAP_BITS + COUNTER_BITS;
    localparam int TIME_BITS    = 64;
    localparam int DELAY_BITS   = 8;

    typedef logic [COUNTER_BITS-1:0] t_tick;
    typedef logic [WRAP_BITS-1:0]    t_wrap;
    typedef logic [TIME_BITS-1:0]    t_time;
    typedef logic [DELAY_BITS-1:0]   t_delay;

    localparam t_tick  TICK_ONE    = t_tick'(1);
    localparam t_tick  TICK_MAX    = '1;
    localparam t_wrap  WRAP_ONE    = t_wrap'(1);
    localparam t_time  TIME_ZERO   = '0;
    localparam t_delay DELAY_RESET = t_delay'(35);
    localparam t_time  SLAVE_RESET = TIME_ZERO - t_time'(DELAY_RESET);

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_TX_CAP = 3'd1,
        KIND_RX_CAP = 3'd2,
        KIND_SYNC   = 3'd3,
        KIND_ARM    = 3'd4,
        KIND_START  = 3'd5,
        KIND_STOP   = 3'd6,
        KIND_CLEAR  = 3'd7
    } t_kind;

    typedef struct packed {
        t_time local_time;
        t_time offset;
        logic  ahead;
        t_time tx;
        t_time rx;
        logic  hit;
    } t_snap;

endpackage

// ----- rtl/synced_timestamp_timer.sv -----
// Top level of the synced timestamp timer: handshakes, snapshot stage and result register.
// Depends on sst_pkg and sst_timebase.
//
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_kind, i_value
// out       output     o_out_valid / i_out_ready   o_sync_time, o_tx_stamp, o_rx_stamp,
//                                                  o_compare_hit
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data
//
// One transaction is accepted per cycle unless both stages are full and the output is stalled;
// the snapshot stage loads on acceptance and feeds the result register, which offers the result.
// The state updates in the accept cycle, a snapshot stage holds it, and the result register
// adds the offset to the local time. Reset is synchronous and needs no clearing pass.
// A stalled output holds the snapshot stage, and input acceptance stops only when both are full.
module synced_timestamp_timer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sst_pkg::t_kind  i_kind,
    input  sst_pkg::t_time  i_value,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  sst_pkg::t_delay i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sst_pkg::t_time  o_sync_time,
    output sst_pkg::t_time  o_tx_stamp,
    output sst_pkg::t_time  o_rx_stamp,
    output logic            o_compare_hit
);
    import sst_pkg::*;

    logic  w_in_accept;
    logic  w_cfg_accept;
    logic  w_p_adv;
    t_snap w_snap;

    logic  r_p_valid;
    t_snap r_p_snap;
    logic  r_o_valid;
    t_time r_o_sync_time;
    t_time r_o_tx;
    t_time r_o_rx;
    logic  r_o_hit;

    assign w_p_adv      = !r_o_valid || i_out_ready;
    assign o_in_ready   = !r_p_valid || w_p_adv;
    assign w_in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready  = 1'b1;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready;

    sst_timebase u_timebase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_in_accept),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .i_cfg_we   (w_cfg_accept),
        .i_cfg_data (i_cfg_data),
        .o_snap     (w_snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_p_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_p_snap <= w_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_p_adv) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_adv && r_p_valid) begin
            r_o_sync_time <= r_p_snap.ahead ? r_p_snap.local_time - r_p_snap.offset
                                            : r_p_snap.local_time + r_p_snap.offset;
            r_o_tx        <= r_p_snap.tx;
            r_o_rx        <= r_p_snap.rx;
            r_o_hit       <= r_p_snap.hit;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_sync_time   = r_o_sync_time;
    assign o_tx_stamp    = r_o_tx;
    assign o_rx_stamp    = r_o_rx;
    assign o_compare_hit = r_o_hit;

`ifndef SYNTHESIS
    a_hit_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_kind != KIND_TICK) |=> !r_p_snap.hit)
        else $error("compare hit raised by a transaction that is not a tick");

    a_start_stop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_kind == KIND_START || i_kind == KIND_STOP))
        |=> (r_p_snap.local_time == TIME_ZERO))
        else $error("start or stop did not clear the time base");

    a_snapshot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !w_p_adv) |=> (r_p_valid && $stable(r_p_snap)))
        else $error("snapshot stage overwritten while the result register was stalled");
`endif

endmodule

// ----- rtl/sst_timebase.sv -----
// Time base, capture, offset and compare state of the synced timestamp timer.
// Updates the state for one accepted transaction and reports the updated state.
// Depends on sst_pkg.
module sst_timebase (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  sst_pkg::t_kind  i_kind,
    input  sst_pkg::t_time  i_value,
    input  logic            i_cfg_we,
    input  sst_pkg::t_delay i_cfg_data,
    output sst_pkg::t_snap  o_snap
);
    import sst_pkg::*;

    t_tick  r_tick,    n_tick;
    t_wrap  r_wrap,    n_wrap;
    logic   r_running, n_running;
    t_time  r_tx,      n_tx;
    t_time  r_rx,      n_rx;
    t_time  r_slave,   n_slave;
    t_time  r_offset,  n_offset;
    logic   r_ahead,   n_ahead;
    t_time  r_target,  n_target;
    logic   r_armed,   n_armed;
    t_delay r_delay,   n_delay;
    logic   w_hit;

    t_time  w_now;
    t_tick  w_tick_inc;
    t_wrap  w_wrap_inc;
    t_time  w_now_inc;
    t_time  w_v_minus_s;
    t_time  w_s_minus_v;
    logic   w_borrow;

    assign w_now       = t_time'({r_wrap, r_tick});
    assign w_tick_inc  = r_tick + TICK_ONE;
    assign w_wrap_inc  = (r_tick == TICK_MAX) ? r_wrap + WRAP_ONE : r_wrap;
    assign w_now_inc   = t_time'({w_wrap_inc, w_tick_inc});
    assign {w_borrow, w_v_minus_s} = {1'b0, i_value} - {1'b0, r_slave};
    assign w_s_minus_v = r_slave - i_value;

    always_comb begin
        n_tick    = r_tick;
        n_wrap    = r_wrap;
        n_running = r_running;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_slave   = r_slave;
        n_offset  = r_offset;
        n_ahead   = r_ahead;
        n_target  = r_target;
        n_armed   = r_armed;
        n_delay   = r_delay;
        w_hit     = 1'b0;
        if (i_accept) begin
            case (i_kind)
                KIND_TICK: begin
                    if (r_running) begin
                        n_tick = w_tick_inc;
                        n_wrap = w_wrap_inc;
                        w_hit  = r_armed && (w_now_inc == r_target);
                    end
                end
                KIND_TX_CAP: begin
                    n_tx = w_now;
                end
                KIND_RX_CAP: begin
                    n_rx    = w_now;
                    n_slave = w_now - t_time'(r_delay);
                end
                KIND_SYNC: begin
                    n_ahead  = w_borrow;
                    n_offset = w_borrow ? w_s_minus_v : w_v_minus_s;
                end
                KIND_ARM: begin
                    n_target = r_ahead ? i_value + r_offset : i_value - r_offset;
                    n_armed  = 1'b1;
                end
                KIND_START: begin
                    n_tick    = '0;
                    n_wrap    = '0;
                    n_running = 1'b1;
                end
                KIND_STOP: begin
                    n_tick    = '0;
                    n_wrap    = '0;
                    n_running = 1'b0;
                end
                KIND_CLEAR: begin
                    n_tx    = TIME_ZERO;
                    n_rx    = TIME_ZERO;
                    n_slave = TIME_ZERO - t_time'(r_delay);
                end
                default: begin
                end
            endcase
        end
        if (i_cfg_we) begin
            n_delay = i_cfg_data;
            n_slave = n_rx - t_time'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_wrap    <= '0;
            r_running <= 1'b0;
            r_tx      <= TIME_ZERO;
            r_rx      <= TIME_ZERO;
            r_slave   <= SLAVE_RESET;
            r_offset  <= TIME_ZERO;
            r_ahead   <= 1'b0;
            r_target  <= TIME_ZERO;
            r_armed   <= 1'b0;
            r_delay   <= DELAY_RESET;
        end else begin
            r_tick    <= n_tick;
            r_wrap    <= n_wrap;
            r_running <= n_running;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_slave   <= n_slave;
            r_offset  <= n_offset;
            r_ahead   <= n_ahead;
            r_target  <= n_target;
            r_armed   <= n_armed;
            r_delay   <= n_delay;
        end
    end

    always_comb begin
        o_snap.local_time = t_time'({n_wrap, n_tick});
        o_snap.offset     = n_offset;
        o_snap.ahead      = n_ahead;
        o_snap.tx         = n_tx;
        o_snap.rx         = n_rx;
        o_snap.hit        = w_hit;
    end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for synced_timestamp_timer: a queue-fed driver, a result monitor
// and a transaction-level model of the time base, sync offset, captures and compare logic.
// Depends on sst_pkg and the synced_timestamp_timer RTL.
module testbench;
    import sst_pkg::*;

    localparam int CLOCK_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 6;

    typedef struct {
        t_kind kind;
        t_time value;
    } t_timer_cmd;

    typedef struct {
        t_time sync_time;
        t_time tx;
        t_time rx;
        logic  hit;
    } t_timer_result;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    t_kind  i_kind      = KIND_TICK;
    t_time  i_value     = '0;
    logic   i_cfg_valid = 1'b0;
    t_delay i_cfg_data  = DELAY_RESET;
    logic   i_out_ready = 1'b0;
    logic   o_in_ready;
    logic   o_cfg_ready;
    logic   o_out_valid;
    t_time  o_sync_time;
    t_time  o_tx_stamp;
    t_time  o_rx_stamp;
    logic   o_compare_hit;

    synced_timestamp_timer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sync_time   (o_sync_time),
        .o_tx_stamp    (o_tx_stamp),
        .o_rx_stamp    (o_rx_stamp),
        .o_compare_hit (o_compare_hit)
    );

    t_timer_cmd    pending_cmds[$];
    t_timer_result expected_results[$];
    t_timer_cmd    next_cmd;

    t_tick  tl_ticks   = '0;
    t_wrap  tl_wraps   = '0;
    logic   tl_running = 1'b0;
    t_time  tl_tx      = '0;
    t_time  tl_rx      = '0;
    t_time  tl_offset  = '0;
    logic   tl_ahead   = 1'b0;
    t_time  tl_target  = '0;
    logic   tl_armed   = 1'b0;
    t_delay tl_delay   = DELAY_RESET;

    t_delay delay_setting   = DELAY_RESET;
    int     send_idle_pct   = 0;
    int     stall_pct       = 0;
    int     hold_requests   = 0;
    int     hold_seen       = 0;
    int     hold_left       = 0;
    int     cmds_queued     = 0;
    int     results_checked = 0;
    int     hits_seen       = 0;
    int     failures        = 0;
    int     clock_count     = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        clock_count <= clock_count + 1;
        if (clock_count >= CLOCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_time rand_time();
        return {$urandom, $urandom};
    endfunction

    // Advances the timer model by one accepted transaction and records the result it yields.
    function automatic void advance_timer(input t_kind kind, input t_time value);
        t_tick         next_tick;
        t_time         slave;
        t_time         now;
        t_timer_result res;
        res.hit = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (tl_running) begin
                    next_tick = tl_ticks + TICK_ONE;
                    if (next_tick == '0) begin
                        tl_wraps = tl_wraps + WRAP_ONE;
                    end
                    tl_ticks = next_tick;
                    if (tl_armed && {tl_wraps, tl_ticks} == tl_target) begin
                        res.hit = 1'b1;
                    end
                end
            end
            KIND_TX_CAP: tl_tx = {tl_wraps, tl_ticks};
            KIND_RX_CAP: tl_rx = {tl_wraps, tl_ticks};
            KIND_SYNC: begin
                slave = tl_rx - t_time'(tl_delay);
                if (slave > value) begin
                    tl_offset = slave - value;
                    tl_ahead  = 1'b1;
                end else begin
                    tl_offset = value - slave;
                    tl_ahead  = 1'b0;
                end
            end
            KIND_ARM: begin
                tl_target = tl_ahead ? value + tl_offset : value - tl_offset;
                tl_armed  = 1'b1;
            end
            KIND_START: begin
                tl_ticks   = '0;
                tl_wraps   = '0;
                tl_running = 1'b1;
            end
            KIND_STOP: begin
                tl_ticks   = '0;
                tl_wraps   = '0;
                tl_running = 1'b0;
            end
            default: begin
                tl_tx = '0;
                tl_rx = '0;
            end
        endcase
        now = {tl_wraps, tl_ticks};
        res.sync_time = tl_ahead ? now - tl_offset : now + tl_offset;
        res.tx = tl_tx;
        res.rx = tl_rx;
        expected_results.push_back(res);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_timer(i_kind, i_value);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_cmd = pending_cmds.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind     <= next_cmd.kind;
                    i_value    <= next_cmd.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Result transaction arrived with no expectation waiting");
                    failures++;
                end else begin
                    if (o_sync_time !== expected_results[0].sync_time) begin
                        $error("sync_time: expected %h, actual %h",
                               expected_results[0].sync_time, o_sync_time);
                        failures++;
                    end
                    if (o_tx_stamp !== expected_results[0].tx) begin
                        $error("tx_stamp: expected %h, actual %h",
                               expected_results[0].tx, o_tx_stamp);
                        failures++;
                    end
                    if (o_rx_stamp !== expected_results[0].rx) begin
                        $error("rx_stamp: expected %h, actual %h",
                               expected_results[0].rx, o_rx_stamp);
                        failures++;
                    end
                    if (o_compare_hit !== expected_results[0].hit) begin
                        $error("compare_hit: expected %b, actual %b",
                               expected_results[0].hit, o_compare_hit);
                        failures++;
                    end
                    if (expected_results[0].hit) begin
                        hits_seen++;
                    end
                    void'(expected_results.pop_front());
                    results_checked++;
                end
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic queue_cmd(input t_kind kind, input t_time value);
        t_timer_cmd cmd;
        cmd.kind  = kind;
        cmd.value = value;
        pending_cmds.push_back(cmd);
        cmds_queued++;
    endtask

    task automatic write_delay(input t_delay delay);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= delay;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        tl_delay      = delay;
        delay_setting = delay;
    endtask

    task automatic wait_drained();
        while (results_checked != cmds_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_directed();
        t_time master;
        queue_cmd(KIND_TICK, '1);
        queue_cmd(KIND_TX_CAP, '0);
        queue_cmd(KIND_RX_CAP, '1);
        queue_cmd(KIND_SYNC, '0);
        queue_cmd(KIND_SYNC, '1);
        queue_cmd(KIND_SYNC, SLAVE_RESET);
        queue_cmd(KIND_ARM, '1);
        queue_cmd(KIND_ARM, '0);
        queue_cmd(KIND_START, '0);
        repeat (4) queue_cmd(KIND_TICK, '0);
        queue_cmd(KIND_TX_CAP, '0);
        // The receive capture of 4 lies below the delay, so the slave time wraps.
        queue_cmd(KIND_RX_CAP, '0);
        master = 64'h8000_0000_0000_0000;
        queue_cmd(KIND_SYNC, master);
        queue_cmd(KIND_ARM, t_time'(6) + master - (t_time'(4) - t_time'(delay_setting)));
        repeat (3) queue_cmd(KIND_TICK, '1);
        queue_cmd(KIND_CLEAR, '1);
        queue_cmd(KIND_STOP, '1);
        queue_cmd(KIND_TICK, '0);
        queue_cmd(KIND_START, '1);
        queue_cmd(KIND_TICK, '1);
    endtask

    // A sync exchange followed by a compare armed a few ticks ahead of the local time.
    task automatic queue_scenario();
        int    lead;
        int    steps;
        t_time slave;
        t_time master;
        t_time now_local;
        lead = $urandom_range(0, 40);
        queue_cmd(KIND_START, rand_time());
        repeat (lead) queue_cmd(KIND_TICK, rand_time());
        if ($urandom_range(0, 1) == 1) begin
            queue_cmd(KIND_TX_CAP, rand_time());
        end
        queue_cmd(KIND_RX_CAP, rand_time());
        slave = t_time'(lead) - t_time'(delay_setting);
        case ($urandom_range(0, 3))
            0: master = slave;
            1: master = slave + t_time'($urandom_range(0, 5000));
            2: master = slave - t_time'($urandom_range(0, 5000));
            default: master = rand_time();
        endcase
        queue_cmd(KIND_SYNC, master);
        steps = $urandom_range(0, 4);
        repeat (steps) queue_cmd(KIND_TICK, rand_time());
        now_local = t_time'(lead + steps);
        queue_cmd(KIND_ARM, now_local + t_time'($urandom_range(0, 12)) + master - slave);
        steps = $urandom_range(0, 18);
        repeat (steps) begin
            case ($urandom_range(0, 19))
                0: queue_cmd(KIND_TX_CAP, rand_time());
                1: queue_cmd(KIND_RX_CAP, rand_time());
                2: queue_cmd(KIND_CLEAR, rand_time());
                3: queue_cmd(KIND_STOP, rand_time());
                default: queue_cmd(KIND_TICK, rand_time());
            endcase
        end
    endtask

    initial begin
        int     goal;
        t_delay delay;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: delay = DELAY_RESET;
                1: delay = '0;
                2: delay = '1;
                4: delay = t_delay'(1);
                default: delay = t_delay'($urandom_range(0, 255));
            endcase
            write_delay(delay);
            case (phase)
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                3: begin send_idle_pct = 31; stall_pct = 31; end
                5: begin send_idle_pct = 31; stall_pct = 73; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            if (phase == 0) begin
                queue_directed();
            end
            // The receiver holds off while the sender keeps offering, so the block fills up.
            if (phase == 4) begin
                hold_requests++;
            end
            goal = cmds_queued + PHASE_ITEMS;
            while (cmds_queued < goal) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        queue_cmd(t_kind'($urandom_range(0, 7)), rand_time());
                    end
                end else begin
                    queue_scenario();
                end
            end
            wait_drained();
        end
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end
        // The tick counter cannot be preloaded, so its wrap lies beyond a run of this length.
        $display("Ran %0d transactions over %0d phases of delay and handshake settings.",
                 cmds_queued, PHASE_COUNT);
        $display("Checked %0d results, %0d of them compare hits.", results_checked, hits_seen);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- synced_timestamp_timer.f -----
rtl/sst_pkg.sv
rtl/sst_timebase.sv
rtl/synced_timestamp_timer.sv
test/testbench.sv
